// File: design/hcm_pkg.sv
`timescale 1ns / 1ps

package hcm_pkg;

    localparam int MAG_W      = 24;
    localparam int SCALE_W    = 16;
    localparam int COL_W      = 8;
    localparam int U_W        = 31;
    localparam int N_W        = 39;
    localparam int Q_W        = 8;
    localparam int DIV_STAGES = Q_W + 1;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd300;
    localparam logic               REG_HEAT_SCALE = 1'b0;
    localparam logic [COL_W-1:0]   COL_MAX        = '1;

    typedef enum logic [1:0] {
        REG_LOW,
        REG_MID,
        REG_HIGH,
        REG_TOP
    } t_region;

    typedef enum logic [1:0] {
        MUL_1,
        MUL_51,
        MUL_255
    } t_mul;

    // scale multiples, derived once per register write
    typedef struct packed {
        logic [U_W-1:0] s256;
        logic [U_W-1:0] s2560;
        logic [U_W-1:0] s25600;
        logic [U_W-1:0] d1024;
        logic [U_W-1:0] d2304;
        logic [U_W-1:0] d5120;
        logic [U_W-1:0] d23040;
    } t_scale;

    typedef struct packed {
        t_region        region;
        t_mul           mul_a;
        t_mul           mul_b;
        logic [U_W-1:0] ua;
        logic [U_W-1:0] ub;
        logic [U_W-1:0] da;
        logic [U_W-1:0] db;
    } t_prep;

    typedef struct packed {
        t_region        region;
        logic [N_W-1:0] na;
        logic [N_W-1:0] nb;
        logic [U_W-1:0] da;
        logic [U_W-1:0] db;
    } t_div_op;

    typedef struct packed {
        logic [N_W-1:0] rem;
        logic [U_W-1:0] den;
        logic [Q_W-1:0] q;
        logic           sat;
    } t_lane;

    typedef struct packed {
        t_region        region;
        logic [Q_W-1:0] qa;
        logic [Q_W-1:0] qb;
    } t_div_res;

    function automatic t_scale scale_terms(input logic [SCALE_W-1:0] raw);
        logic [U_W-1:0] s;
        t_scale         t;
        s        = (raw == '0) ? U_W'(1) : U_W'(raw);
        t.s256   = s << 8;
        t.s2560  = (s << 11) + (s << 9);
        t.s25600 = (t.s2560 << 3) + (t.s2560 << 1);
        t.d1024  = s << 10;
        t.d2304  = (s << 11) + (s << 8);
        t.d5120  = (s << 12) + (s << 10);
        t.d23040 = (t.d2304 << 3) + (t.d2304 << 1);
        return t;
    endfunction

    function automatic logic [N_W-1:0] mul_const(input t_mul k, input logic [U_W-1:0] u);
        logic [N_W-1:0] x;
        logic [N_W-1:0] y;
        x = N_W'(u);
        case (k)
            MUL_51:  y = (x << 5) + (x << 4) + (x << 1) + x;
            MUL_255: y = (x << 8) - x;
            default: y = x;
        endcase
        return y;
    endfunction

    // one restoring step; the top step only flags a quotient past 255
    function automatic t_lane lane_step(input t_lane l, input int unsigned k);
        logic [N_W-1:0] dsh;
        t_lane          o;
        dsh = N_W'(l.den) << k;
        o   = l;
        if (k == Q_W) begin
            o.sat = (l.rem >= dsh);
        end else if (l.rem >= dsh) begin
            o.rem = l.rem - dsh;
            o.q   = l.q | (Q_W'(1) << k);
        end
        return o;
    endfunction

endpackage

// File: design/hcm_prep.sv
`timescale 1ns / 1ps

module hcm_prep (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [hcm_pkg::MAG_W-1:0]  i_magnitude,
    input  hcm_pkg::t_scale            i_scale,
    output logic                       o_ready,
    output logic                       o_valid,
    output hcm_pkg::t_div_op           o_op,
    input  logic                       i_ready
);
    import hcm_pkg::*;

    logic           r_s1_v;
    t_prep          r_s1;
    logic           r_s2_v;
    t_div_op        r_s2;
    t_prep          n_s1;
    t_div_op        n_s2;
    logic [U_W-1:0] w_m;
    logic [U_W-1:0] w_m10;
    logic           w_rdy1;
    logic           w_rdy2;

    assign w_rdy2  = ~r_s2_v | i_ready;
    assign w_rdy1  = ~r_s1_v | w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_s2_v;
    assign o_op    = r_s2;

    assign w_m   = U_W'(i_magnitude);
    assign w_m10 = (w_m << 3) + (w_m << 1);

    always_comb begin
        n_s1 = '0;
        if (w_m10 < i_scale.s256) begin
            n_s1.region = REG_LOW;
            n_s1.mul_a  = MUL_255;
            n_s1.mul_b  = MUL_1;
            n_s1.ua     = w_m10;
            n_s1.ub     = '0;
            n_s1.da     = i_scale.s256;
            n_s1.db     = i_scale.s256;
        end else if (w_m < i_scale.s256) begin
            n_s1.region = REG_MID;
            n_s1.mul_a  = MUL_255;
            n_s1.mul_b  = MUL_255;
            n_s1.ua     = i_scale.s2560 - w_m10;
            n_s1.ub     = w_m10 - i_scale.s256;
            n_s1.da     = i_scale.d2304;
            n_s1.db     = i_scale.d2304;
        end else if (w_m < i_scale.s2560) begin
            n_s1.region = REG_HIGH;
            n_s1.mul_a  = MUL_255;
            n_s1.mul_b  = MUL_255;
            n_s1.ua     = i_scale.s25600 - w_m10;
            n_s1.ub     = w_m10 - i_scale.s2560;
            n_s1.da     = i_scale.d23040;
            n_s1.db     = i_scale.d23040;
        end else begin
            n_s1.region = REG_TOP;
            n_s1.mul_a  = MUL_1;
            n_s1.mul_b  = MUL_51;
            n_s1.ua     = w_m;
            n_s1.ub     = w_m;
            n_s1.da     = i_scale.d1024;
            n_s1.db     = i_scale.d5120;
        end
    end

    always_comb begin
        n_s2.region = r_s1.region;
        n_s2.na     = mul_const(r_s1.mul_a, r_s1.ua);
        n_s2.nb     = mul_const(r_s1.mul_b, r_s1.ub);
        n_s2.da     = r_s1.da;
        n_s2.db     = r_s1.db;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_v <= i_valid;
            end
            if (w_rdy2) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1 <= n_s1;
        end
        if (w_rdy2) begin
            r_s2 <= n_s2;
        end
    end

endmodule

// File: design/hcm_div.sv
`timescale 1ns / 1ps

module hcm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hcm_pkg::t_div_op   i_op,
    output logic               o_ready,
    output logic               o_valid,
    output hcm_pkg::t_div_res  o_res,
    input  logic               i_ready
);
    import hcm_pkg::*;

    logic [DIV_STAGES-1:0] r_v;
    t_lane                 r_la  [0:DIV_STAGES-1];
    t_lane                 r_lb  [0:DIV_STAGES-1];
    t_region               r_rg  [0:DIV_STAGES-1];
    t_lane                 w_la  [0:DIV_STAGES];
    t_lane                 w_lb  [0:DIV_STAGES];
    t_region               w_rg  [0:DIV_STAGES];
    logic [DIV_STAGES:0]   w_v;
    logic [DIV_STAGES:0]   w_rdy;

    assign w_la[0] = '{rem: i_op.na, den: i_op.da, q: '0, sat: 1'b0};
    assign w_lb[0] = '{rem: i_op.nb, den: i_op.db, q: '0, sat: 1'b0};
    assign w_rg[0] = i_op.region;
    assign w_v[0]  = i_valid;

    assign w_rdy[DIV_STAGES] = i_ready;
    assign o_ready           = w_rdy[0];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        assign w_rdy[j]  = ~r_v[j] | w_rdy[j+1];
        assign w_la[j+1] = r_la[j];
        assign w_lb[j+1] = r_lb[j];
        assign w_rg[j+1] = r_rg[j];
        assign w_v[j+1]  = r_v[j];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= w_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j]) begin
                r_la[j] <= lane_step(w_la[j], Q_W - j);
                r_lb[j] <= lane_step(w_lb[j], Q_W - j);
                r_rg[j] <= w_rg[j];
            end
        end
    end

    assign o_valid      = w_v[DIV_STAGES];
    assign o_res.region = w_rg[DIV_STAGES];
    assign o_res.qa     = w_la[DIV_STAGES].sat ? COL_MAX : w_la[DIV_STAGES].q;
    assign o_res.qb     = w_lb[DIV_STAGES].sat ? COL_MAX : w_lb[DIV_STAGES].q;

endmodule

// File: design/heatmap_color_map_unit.sv
`timescale 1ns / 1ps

// Heatmap color map: one unsigned Q16.8 magnitude in, one 8-bit RGB color out.
// Input channel: i_in_valid / o_in_stall with i_magnitude. A beat is taken at
// a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_red, o_green, o_blue,
// held from a final output register.
// heat_scale sits at byte address 0 of the APB port (reads back the value,
// pready tied high). Write it only while no beat is in flight; 0 acts as 1.
// The pipeline holds two operand-prep stages, nine stages of a pair of
// restoring dividers (a saturation check, then one quotient bit a stage) and
// the output register. It takes one beat per cycle while o_in_stall is low.
// A stall on the output holds the output register; stages behind it keep
// filling any empty slots, and o_in_stall rises only once every stage holds
// a beat. Nothing is dropped or repeated.
// Reset empties the pipeline and loads heat_scale with 300.
module heatmap_color_map_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [hcm_pkg::MAG_W-1:0]   i_magnitude,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hcm_pkg::COL_W-1:0]   o_red,
    output logic [hcm_pkg::COL_W-1:0]   o_green,
    output logic [hcm_pkg::COL_W-1:0]   o_blue,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hcm_pkg::ADDR_W-1:0]  paddr,
    input  logic [hcm_pkg::DATA_W-1:0]  pwdata,
    output logic [hcm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import hcm_pkg::*;

    logic [SCALE_W-1:0] r_scale;
    t_scale             r_terms;
    logic               r_out_valid;
    logic [COL_W-1:0]   r_red;
    logic [COL_W-1:0]   r_green;
    logic [COL_W-1:0]   r_blue;
    logic [COL_W-1:0]   n_red;
    logic [COL_W-1:0]   n_green;
    logic [COL_W-1:0]   n_blue;
    logic               w_wr;
    logic               w_prep_ready;
    logic               w_prep_valid;
    t_div_op            w_op;
    logic               w_div_ready;
    logic               w_div_valid;
    t_div_res           w_res;
    logic               w_out_rdy;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready & (paddr[2] == REG_HEAT_SCALE);
    assign prdata = (paddr[2] == REG_HEAT_SCALE) ? DATA_W'(r_scale) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RST;
            r_terms <= scale_terms(SCALE_RST);
        end else if (w_wr) begin
            r_scale <= pwdata[SCALE_W-1:0];
            r_terms <= scale_terms(pwdata[SCALE_W-1:0]);
        end
    end

    hcm_prep u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_magnitude (i_magnitude),
        .i_scale     (r_terms),
        .o_ready     (w_prep_ready),
        .o_valid     (w_prep_valid),
        .o_op        (w_op),
        .i_ready     (w_div_ready)
    );

    hcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prep_valid),
        .i_op    (w_op),
        .o_ready (w_div_ready),
        .o_valid (w_div_valid),
        .o_res   (w_res),
        .i_ready (w_out_rdy)
    );

    assign o_in_stall = ~w_prep_ready;
    assign w_out_rdy  = ~r_out_valid | ~i_out_stall;

    always_comb begin
        case (w_res.region)
            REG_LOW: begin
                n_red   = '0;
                n_green = '0;
                n_blue  = w_res.qa;
            end
            REG_MID: begin
                n_red   = '0;
                n_green = w_res.qb;
                n_blue  = w_res.qa;
            end
            REG_HIGH: begin
                n_red   = w_res.qb;
                n_green = w_res.qa;
                n_blue  = '0;
            end
            default: begin
                n_red   = COL_MAX;
                n_green = w_res.qa;
                n_blue  = w_res.qb;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;

endmodule

// File: design/hcm_checker.sv
`timescale 1ns / 1ps

module hcm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [hcm_pkg::COL_W-1:0]   o_red,
    input logic [hcm_pkg::COL_W-1:0]   o_green,
    input logic [hcm_pkg::COL_W-1:0]   o_blue
);
    import hcm_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable({o_red, o_green, o_blue}))
        else $error("output beat changed under stall");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    a_red_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_red != '0 && o_red != COL_MAX |-> o_blue == '0)
        else $error("blue set on red ramp");

endmodule

bind heatmap_color_map_unit hcm_checker u_hcm_checker (.*);

// File: tb/tb_heatmap_color_map_unit.sv
`timescale 1ns / 1ps

module tb_heatmap_color_map_unit;
    import hcm_pkg::*;

    localparam int          LATENCY    = 12;
    localparam int          LONG_HOLD  = 60;
    localparam int          WATCHDOG   = 3000;
    localparam int          PHASES     = 6;
    localparam int          PHASE_LEN  = 300;
    localparam int unsigned MAG_MAX    = (1 << MAG_W) - 1;
    localparam logic [ADDR_W-1:0] SCALE_ADDR = ADDR_W'({REG_HEAT_SCALE, 2'b00});

    typedef struct packed {
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_rgb;

    typedef enum bit {
        ROW_ITEM,
        ROW_SCALE
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [MAG_W-1:0] value;
        bit               typed;
        t_rgb             want;
    } t_dir_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    logic [MAG_W-1:0]    in_mag      = '0;
    logic                out_stall   = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [COL_W-1:0]    o_red;
    logic [COL_W-1:0]    o_green;
    logic [COL_W-1:0]    o_blue;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    t_rgb                pending_colors[$];
    logic [SCALE_W-1:0]  scale_shadow = SCALE_RST;
    int unsigned         beats_in     = 0;
    int unsigned         errors       = 0;
    int unsigned         idle_cycles  = 0;
    bit                  calm         = 1'b0;

    // directed beats under the reset scale of 300, then scale 0, 65535 and 1
    t_dir_row directed [0:21] = '{
        {ROW_ITEM,  24'd0,        1'b1, 8'd0,   8'd0,   8'd0  },
        {ROW_ITEM,  24'd7679,     1'b1, 8'd0,   8'd0,   8'd254},
        {ROW_ITEM,  24'd7680,     1'b1, 8'd0,   8'd0,   8'd255},
        {ROW_ITEM,  24'd76800,    1'b1, 8'd0,   8'd255, 8'd0  },
        {ROW_ITEM,  24'd767999,   1'b1, 8'd254, 8'd0,   8'd0  },
        {ROW_ITEM,  24'd768000,   1'b1, 8'd255, 8'd2,   8'd25 },
        {ROW_ITEM,  24'hFFFFFF,   1'b1, 8'd255, 8'd54,  8'd255},
        {ROW_ITEM,  24'd40000,    1'b0, 24'd0},
        {ROW_ITEM,  24'd400000,   1'b0, 24'd0},
        {ROW_ITEM,  24'hAAAAAA,   1'b0, 24'd0},
        {ROW_ITEM,  24'h555555,   1'b0, 24'd0},
        {ROW_SCALE, 24'd0,        1'b0, 24'd0},
        {ROW_ITEM,  24'hFFFFFF,   1'b1, 8'd255, 8'd255, 8'd255},
        {ROW_ITEM,  24'd25,       1'b1, 8'd0,   8'd0,   8'd249},
        {ROW_ITEM,  24'd100,      1'b0, 24'd0},
        {ROW_SCALE, 24'd65535,    1'b0, 24'd0},
        {ROW_ITEM,  24'hFFFFFF,   1'b0, 24'd0},
        {ROW_ITEM,  24'd0,        1'b1, 8'd0,   8'd0,   8'd0  },
        {ROW_ITEM,  24'd16776959, 1'b0, 24'd0},
        {ROW_SCALE, 24'd1,        1'b0, 24'd0},
        {ROW_ITEM,  24'd256,      1'b0, 24'd0},
        {ROW_ITEM,  24'd2560,     1'b1, 8'd255, 8'd2,   8'd25 }
    };

    heatmap_color_map_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_magnitude (in_mag),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [COL_W-1:0] sat8(input longint unsigned x);
        return (x > 255) ? COL_MAX : x[COL_W-1:0];
    endfunction

    function automatic t_rgb heat_color(input logic [MAG_W-1:0] mag,
                                        input logic [SCALE_W-1:0] scale);
        longint unsigned m, s, m10, r, g, b;
        t_rgb            c;
        m   = 64'(mag);
        s   = (scale == '0) ? 64'd1 : 64'(scale);
        m10 = 10 * m;
        if (m10 < 256 * s) begin
            r = 0;
            g = 0;
            b = (255 * m10) / (256 * s);
        end else if (m < 256 * s) begin
            r = 0;
            b = (255 * (2560 * s - m10)) / (2304 * s);
            g = (255 * (m10 - 256 * s)) / (2304 * s);
        end else if (m < 2560 * s) begin
            b = 0;
            g = (255 * (25600 * s - m10)) / (23040 * s);
            r = (255 * (m10 - 2560 * s)) / (23040 * s);
        end else begin
            r = 255;
            g = m / (1024 * s);
            b = (51 * m) / (5120 * s);
        end
        c.red   = sat8(r);
        c.green = sat8(g);
        c.blue  = sat8(b);
        return c;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned idle_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // magnitudes spread over the four regions and their boundaries
    function automatic logic [MAG_W-1:0] random_mag(input logic [SCALE_W-1:0] scale);
        longint unsigned s, lo, mid, hi, v, top;
        s   = (scale == '0) ? 64'd1 : 64'(scale);
        lo  = (256 * s + 9) / 10;
        mid = 256 * s;
        hi  = 2560 * s;
        top = (hi > MAG_MAX) ? MAG_MAX : hi - 1;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom_range(0, MAG_MAX);
            2: v = $urandom_range(0, lo - 1);
            3: v = $urandom_range(lo, mid - 1);
            4: v = $urandom_range(mid, top);
            5: v = (hi > MAG_MAX) ? MAG_MAX - $urandom_range(0, 255)
                                  : $urandom_range(hi, MAG_MAX);
            6: begin
                case ($urandom_range(0, 2))
                    0: v = lo;
                    1: v = mid;
                    default: v = hi;
                endcase
                v = v + $urandom_range(0, 2) - 1;
            end
            7: v = $urandom_range(0, 255);
            default: v = MAG_MAX - $urandom_range(0, 4095);
        endcase
        return (v > MAG_MAX) ? MAG_W'(MAG_MAX) : v[MAG_W-1:0];
    endfunction

    function automatic logic [SCALE_W-1:0] phase_scale(input int ph);
        case (ph)
            0: return SCALE_W'($urandom_range(1, 50));
            1: return '1;
            2: return '0;
            3: return SCALE_W'($urandom_range(0, 65535));
            4: return SCALE_W'($urandom_range(100, 3000));
            default: return SCALE_W'(1);
        endcase
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endtask

    task automatic send_mag(input logic [MAG_W-1:0] mag, input bit typed, input t_rgb want);
        int unsigned gap;
        gap = calm ? 0 : idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_mag   <= mag;
        do @(posedge i_clk); while (o_in_stall);
        pending_colors.push_back(typed ? want : heat_color(mag, scale_shadow));
        beats_in++;
    endtask

    // sender pauses until every pending color has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SCALE_ADDR;
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        scale_shadow = val;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(val))
            flag_error($sformatf("heat_scale readback: exp %0d got %0d", val, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin : check_colors
        t_rgb want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_colors.size() == 0) begin
                flag_error($sformatf("unexpected color r=%0d g=%0d b=%0d",
                                     o_red, o_green, o_blue));
            end else begin
                want = pending_colors.pop_front();
                if (o_red !== want.red || o_green !== want.green || o_blue !== want.blue)
                    flag_error($sformatf("color mismatch: exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                         want.red, want.green, want.blue,
                                         o_red, o_green, o_blue));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // output side: random stall, one long hold-off to back the pipe up
    initial begin : out_side
        int unsigned n;
        bit          held;
        held = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held && beats_in >= 500) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm) begin
                n = idle_len();
                if (n != 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin : in_side
        int ph;
        int k;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_SCALE) begin
                settle();
                write_scale(directed[i].value[SCALE_W-1:0]);
            end else begin
                send_mag(directed[i].value, directed[i].typed, directed[i].want);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            write_scale(phase_scale(ph));
            calm = (ph == 3);
            for (k = 0; k < PHASE_LEN; k++)
                send_mag(random_mag(scale_shadow), 1'b0, '0);
        end

        settle();
        repeat (3 * LATENCY) @(posedge i_clk);
        if (errors == 0 && pending_colors.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
